>>> src/ihs_pkg.sv
// ----------------------------------------------------------------------------
// ihs_pkg
// Shared types and constants for the IPv4 chained hash set.
// ----------------------------------------------------------------------------
package ihs_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned OCT_W      = 8;
  localparam int unsigned COEF_W     = 10;
  localparam int unsigned NUM_COEF   = 4;
  localparam int unsigned PROD_W     = 18;
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned BCNT_W     = 11;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned MARK_W     = 4;
  localparam int unsigned SLOT_W     = 10;
  localparam logic [BCNT_W-1:0] BUCKETS_RESET = 11'd1021;
  localparam logic [COEF_W-1:0] COEF_RESET    = 10'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_FOUND     = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUCKETS     = 3'd0,
    CFG_COEF_FIRST  = 3'd1,
    CFG_COEF_SECOND = 3'd2,
    CFG_COEF_THIRD  = 3'd3,
    CFG_COEF_FOURTH = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_SUM,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    E_CLEAR,
    E_IDLE,
    E_LEN,
    E_SRCH,
    E_CMP,
    E_ACT,
    E_SHR,
    E_SHW,
    E_SCAN,
    E_DRAIN,
    E_DONE
  } eng_state_e;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  insert_total;
    logic [CNT_W-1:0]  delete_total;
    logic [BCNT_W-1:0] empty_buckets;
    logic [BCNT_W-1:0] single_buckets;
    logic [MARK_W-1:0] longest_chain;
    logic [SLOT_W-1:0] longest_slot;
  } result_t;

endpackage

>>> src/ihs_if.sv
// ----------------------------------------------------------------------------
// ihs_if
// Handshake channels of the IPv4 chained hash set: command, result, config.
// ----------------------------------------------------------------------------
interface ihs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] ip_address;
  modport source (output valid, cmd, ip_address, input ready);
  modport sink   (input valid, cmd, ip_address, output ready);
endinterface

interface ihs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] insert_total;
  logic [31:0] delete_total;
  logic [10:0] empty_buckets;
  logic [10:0] single_buckets;
  logic [3:0]  longest_chain;
  logic [9:0]  longest_slot;
  modport source (output valid, status, insert_total, delete_total, empty_buckets,
                  single_buckets, longest_chain, longest_slot, input ready);
  modport sink   (input valid, status, insert_total, delete_total, empty_buckets,
                  single_buckets, longest_chain, longest_slot, output ready);
endinterface

interface ihs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/ihs_hash.sv
// ----------------------------------------------------------------------------
// ihs_hash
// Front end: takes a command, forms the weighted octet sum and reduces it
// modulo the bucket count with a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module ihs_hash #(
  parameter int unsigned BW = 10,
  parameter int unsigned NW = 11
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       enable_i,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic [ihs_pkg::CMD_W-1:0]                  in_cmd_i,
  input  logic [ihs_pkg::ADDR_W-1:0]                 in_addr_i,
  input  logic [NW-1:0]                              n_i,
  input  logic [ihs_pkg::NUM_COEF-1:0][ihs_pkg::COEF_W-1:0] coef_i,
  output logic                                       job_valid_o,
  input  logic                                       job_ready_i,
  output logic [ihs_pkg::CMD_W-1:0]                  job_cmd_o,
  output logic [ihs_pkg::ADDR_W-1:0]                 job_addr_o,
  output logic [BW-1:0]                              job_bucket_o
);

  ihs_pkg::front_state_e state_q, state_d;

  logic [ihs_pkg::CMD_W-1:0]                          cmd_q;
  logic [ihs_pkg::ADDR_W-1:0]                         addr_q;
  logic [ihs_pkg::NUM_COEF-1:0][ihs_pkg::PROD_W-1:0]  prod_q;
  logic [ihs_pkg::SUM_W-1:0]                          sum_q, sum_d;
  logic [NW-1:0]                                      rem_q, rem_d;
  logic [ihs_pkg::DIV_CNT_W-1:0]                      cnt_q, cnt_d;
  logic [NW:0]                                        trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ihs_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= in_cmd_i;
      addr_q <= in_addr_i;
    end
    if (state_q == ihs_pkg::F_MUL) begin
      for (int k = 0; k < ihs_pkg::NUM_COEF; k++) begin
        prod_q[k] <= ihs_pkg::PROD_W'(addr_q[k*ihs_pkg::OCT_W +: ihs_pkg::OCT_W])
                   * ihs_pkg::PROD_W'(coef_i[k]);
      end
    end
    sum_q <= sum_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  // shift in the next dividend bit, subtract when it fits
  assign trial = {rem_q, sum_q[ihs_pkg::SUM_W-1]};

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    job_valid_o = 1'b0;
    unique case (state_q)
      ihs_pkg::F_IDLE: begin
        in_ready_o = enable_i;
        if (in_valid_i && enable_i) begin
          state_d = ihs_pkg::F_MUL;
        end
      end
      ihs_pkg::F_MUL: begin
        state_d = ihs_pkg::F_SUM;
      end
      ihs_pkg::F_SUM: begin
        sum_d   = ihs_pkg::SUM_W'(prod_q[0]) + ihs_pkg::SUM_W'(prod_q[1])
                + ihs_pkg::SUM_W'(prod_q[2]) + ihs_pkg::SUM_W'(prod_q[3]);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ihs_pkg::F_DIV;
      end
      ihs_pkg::F_DIV: begin
        if (trial >= {1'b0, n_i}) begin
          rem_d = NW'(trial - {1'b0, n_i});
        end else begin
          rem_d = NW'(trial);
        end
        sum_d = {sum_q[ihs_pkg::SUM_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ihs_pkg::DIV_CNT_W'(ihs_pkg::SUM_W - 1)) begin
          state_d = ihs_pkg::F_PUSH;
        end
      end
      ihs_pkg::F_PUSH: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          state_d = ihs_pkg::F_IDLE;
        end
      end
      default: state_d = ihs_pkg::F_IDLE;
    endcase
  end

  assign job_cmd_o    = cmd_q;
  assign job_addr_o   = addr_q;
  assign job_bucket_o = BW'(rem_q);

endmodule

>>> src/ihs_queue.sv
// ----------------------------------------------------------------------------
// ihs_queue
// Two-entry job queue between the hash front end and the table engine.
// ----------------------------------------------------------------------------
module ihs_queue #(
  parameter int unsigned W = 44
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [1:0][W-1:0] slot_q;
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> src/ihs_engine.sv
// ----------------------------------------------------------------------------
// ihs_engine
// Back end: chain search, insert, delete with shift-up, and the bucket scan
// that produces the occupancy counts and the high-water mark.
// ----------------------------------------------------------------------------
module ihs_engine #(
  parameter int unsigned MAX_BUCKETS = 1024,
  parameter int unsigned CHAIN_DEPTH = 8,
  parameter int unsigned BW          = 10,
  parameter int unsigned NW          = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [NW-1:0]               n_i,
  input  logic                        job_valid_i,
  output logic                        job_ready_o,
  input  logic [ihs_pkg::CMD_W-1:0]   job_cmd_i,
  input  logic [ihs_pkg::ADDR_W-1:0]  job_addr_i,
  input  logic [BW-1:0]               job_bucket_i,
  output logic                        init_done_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ihs_pkg::result_t            result_o
);

  localparam int unsigned CW    = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned DEPTH = MAX_BUCKETS * CHAIN_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ihs_pkg::eng_state_e state_q, state_d;

  // memories
  logic [ihs_pkg::ADDR_W-1:0] ent_mem [DEPTH];
  logic [CW-1:0]              len_mem [MAX_BUCKETS];

  logic [ihs_pkg::ADDR_W-1:0] ent_rd_q;
  logic [CW-1:0]              len_rd_q;
  logic [AW-1:0]              ent_raddr, ent_waddr;
  logic                       ent_we;
  logic [ihs_pkg::ADDR_W-1:0] ent_wdata;
  logic [BW-1:0]              len_raddr, len_waddr;
  logic                       len_we;
  logic [CW-1:0]              len_wdata;

  // job and working registers
  logic [ihs_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [ihs_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [BW-1:0]              bucket_q, bucket_d;
  logic [CW-1:0]              len_q, len_d;
  logic [CW-1:0]              idx_q, idx_d;
  logic [CW-1:0]              pos_q, pos_d;
  logic [ihs_pkg::STAT_W-1:0] status_q, status_d;
  logic                       do_mark_q, do_mark_d;
  logic [BW-1:0]              clr_q, clr_d;
  logic [BW-1:0]              sidx_q, sidx_d;
  logic [BW-1:0]              pidx_q, pidx_d;
  logic                       pv_q, pv_d;
  logic [NW-1:0]              empt_q, empt_d;
  logic [NW-1:0]              sing_q, sing_d;
  logic [ihs_pkg::CNT_W-1:0]  ins_q, ins_d;
  logic [ihs_pkg::CNT_W-1:0]  del_q, del_d;
  logic [CW-1:0]              mlen_q, mlen_d;
  logic [BW-1:0]              mslot_q, mslot_d;
  logic                       ovalid_q, ovalid_d;
  ihs_pkg::result_t           res_q, res_d;
  logic [AW-1:0]              base;

  assign base = AW'(bucket_q) * AW'(CHAIN_DEPTH);

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd_q <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_rd_q <= len_mem[len_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ihs_pkg::E_CLEAR;
      clr_q     <= '0;
      pv_q      <= 1'b0;
      ins_q     <= '0;
      del_q     <= '0;
      mlen_q    <= '0;
      mslot_q   <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      pv_q      <= pv_d;
      ins_q     <= ins_d;
      del_q     <= del_d;
      mlen_q    <= mlen_d;
      mslot_q   <= mslot_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    addr_q    <= addr_d;
    bucket_q  <= bucket_d;
    len_q     <= len_d;
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    status_q  <= status_d;
    do_mark_q <= do_mark_d;
    sidx_q    <= sidx_d;
    pidx_q    <= pidx_d;
    empt_q    <= empt_d;
    sing_q    <= sing_d;
    res_q     <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    bucket_d  = bucket_q;
    len_d     = len_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    status_d  = status_q;
    do_mark_d = do_mark_q;
    clr_d     = clr_q;
    sidx_d    = sidx_q;
    pidx_d    = pidx_q;
    pv_d      = pv_q;
    empt_d    = empt_q;
    sing_d    = sing_q;
    ins_d     = ins_q;
    del_d     = del_q;
    mlen_d    = mlen_q;
    mslot_d   = mslot_q;
    ovalid_d  = ovalid_q;
    res_d     = res_q;

    job_ready_o = 1'b0;
    ent_raddr   = base + AW'(idx_q);
    ent_we      = 1'b0;
    ent_waddr   = base + AW'(len_q);
    ent_wdata   = addr_q;
    len_raddr   = sidx_q;
    len_we      = 1'b0;
    len_waddr   = bucket_q;
    len_wdata   = len_q + 1'b1;

    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end

    // scan pipeline: length read last cycle is folded in now
    if (pv_q) begin
      if (len_rd_q == '0) begin
        empt_d = empt_q + 1'b1;
      end else if (len_rd_q == CW'(1)) begin
        sing_d = sing_q + 1'b1;
      end
      if (do_mark_q && (len_rd_q >= mlen_q)) begin
        mlen_d  = len_rd_q;
        mslot_d = pidx_q;
      end
    end

    unique case (state_q)
      ihs_pkg::E_CLEAR: begin
        len_we    = 1'b1;
        len_waddr = clr_q;
        len_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == BW'(MAX_BUCKETS - 1)) begin
          state_d = ihs_pkg::E_IDLE;
        end
      end
      ihs_pkg::E_IDLE: begin
        job_ready_o = 1'b1;
        len_raddr   = job_bucket_i;
        if (job_valid_i) begin
          cmd_d    = job_cmd_i;
          addr_d   = job_addr_i;
          bucket_d = job_bucket_i;
          state_d  = ihs_pkg::E_LEN;
        end
      end
      ihs_pkg::E_LEN: begin
        len_d     = len_rd_q;
        idx_d     = '0;
        do_mark_d = 1'b0;
        status_d  = ihs_pkg::ST_NOT_FOUND;
        pos_d     = '0;
        state_d   = ihs_pkg::E_SRCH;
      end
      ihs_pkg::E_SRCH: begin
        if (idx_q < len_q) begin
          state_d = ihs_pkg::E_CMP;
        end else begin
          state_d = ihs_pkg::E_ACT;
        end
      end
      ihs_pkg::E_CMP: begin
        if (ent_rd_q == addr_q) begin
          pos_d    = idx_q;
          status_d = ihs_pkg::ST_FOUND;
          state_d  = ihs_pkg::E_ACT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ihs_pkg::E_SRCH;
        end
      end
      ihs_pkg::E_ACT: begin
        sidx_d  = '0;
        empt_d  = '0;
        sing_d  = '0;
        pv_d    = 1'b0;
        state_d = ihs_pkg::E_SCAN;
        case (cmd_q)
          ihs_pkg::CMD_INSERT: begin
            if (status_q == ihs_pkg::ST_FOUND) begin
              status_d = ihs_pkg::ST_DUPLICATE;
            end else if (len_q >= CW'(CHAIN_DEPTH)) begin
              status_d = ihs_pkg::ST_FULL;
            end else begin
              ent_we    = 1'b1;
              len_we    = 1'b1;
              ins_d     = ins_q + 1'b1;
              do_mark_d = 1'b1;
              status_d  = ihs_pkg::ST_INSERTED;
            end
          end
          ihs_pkg::CMD_DELETE: begin
            if (status_q == ihs_pkg::ST_FOUND) begin
              idx_d   = pos_q;
              state_d = ihs_pkg::E_SHR;
            end else begin
              status_d = ihs_pkg::ST_ABSENT;
            end
          end
          ihs_pkg::CMD_LOOKUP: begin
            status_d = status_q;
          end
          default: begin
            status_d = ihs_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      ihs_pkg::E_SHR: begin
        ent_raddr = base + AW'(idx_q) + AW'(1);
        if ((idx_q + 1'b1) < len_q) begin
          state_d = ihs_pkg::E_SHW;
        end else begin
          len_we    = 1'b1;
          len_wdata = len_q - 1'b1;
          del_d     = del_q + 1'b1;
          status_d  = ihs_pkg::ST_DELETED;
          state_d   = ihs_pkg::E_SCAN;
        end
      end
      ihs_pkg::E_SHW: begin
        ent_we    = 1'b1;
        ent_waddr = base + AW'(idx_q);
        ent_wdata = ent_rd_q;
        idx_d     = idx_q + 1'b1;
        state_d   = ihs_pkg::E_SHR;
      end
      ihs_pkg::E_SCAN: begin
        len_raddr = sidx_q;
        pv_d      = 1'b1;
        pidx_d    = sidx_q;
        sidx_d    = sidx_q + 1'b1;
        if (sidx_q == BW'(n_i - 1'b1)) begin
          state_d = ihs_pkg::E_DRAIN;
        end
      end
      ihs_pkg::E_DRAIN: begin
        pv_d    = 1'b0;
        state_d = ihs_pkg::E_DONE;
      end
      ihs_pkg::E_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d             = 1'b1;
          res_d.status         = status_q;
          res_d.insert_total   = ins_q;
          res_d.delete_total   = del_q;
          res_d.empty_buckets  = ihs_pkg::BCNT_W'(empt_q);
          res_d.single_buckets = ihs_pkg::BCNT_W'(sing_q);
          res_d.longest_chain  = ihs_pkg::MARK_W'(mlen_q);
          res_d.longest_slot   = ihs_pkg::SLOT_W'(mslot_q);
          state_d              = ihs_pkg::E_IDLE;
        end
      end
      default: state_d = ihs_pkg::E_IDLE;
    endcase
  end

  assign init_done_o = (state_q != ihs_pkg::E_CLEAR);
  assign out_valid_o = ovalid_q;
  assign result_o    = res_q;

endmodule

>>> src/ipv4_chained_hash_set_top.sv
// ----------------------------------------------------------------------------
// ipv4_chained_hash_set_top
// Set of IPv4 addresses in a chained hash table with occupancy statistics.
//
//   channel  dir  payload
//   in_i     in   cmd, ip_address
//   out_o    out  status, totals, bucket counts, high-water mark
//   cfg_i    in   index, data (bucket count, four coefficients)
//
// The table engine's time per command is set by the one-bucket-per-cycle length
// scan over the n buckets in use, plus the chain search and shift (L chain
// length); the hash front end overlaps the previous command.
// After reset a clearing pass writes MAX_BUCKETS chain lengths, one per cycle,
// while no command is taken. A stalled result register holds the engine;
// the two-entry queue lets the front end keep hashing meanwhile.
// ----------------------------------------------------------------------------
module ipv4_chained_hash_set_top #(
  parameter int unsigned MAX_BUCKETS = 1024,
  parameter int unsigned CHAIN_DEPTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ihs_in_if.sink    in_i,
  ihs_out_if.source out_o,
  ihs_cfg_if.sink   cfg_i
);

  localparam int unsigned BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned NW    = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned JOB_W = ihs_pkg::CMD_W + ihs_pkg::ADDR_W + BW;

  logic [ihs_pkg::BCNT_W-1:0]                         bucket_count_q;
  logic [ihs_pkg::NUM_COEF-1:0][ihs_pkg::COEF_W-1:0]  coef_q;
  logic [NW-1:0]                                      n_buckets;

  logic                        init_done;
  logic                        fq_valid, fq_ready, qe_valid, qe_ready;
  logic [ihs_pkg::CMD_W-1:0]   f_cmd;
  logic [ihs_pkg::ADDR_W-1:0]  f_addr;
  logic [BW-1:0]               f_bucket;
  logic [JOB_W-1:0]            q_in, q_out;
  ihs_pkg::result_t            result;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= ihs_pkg::BUCKETS_RESET;
      coef_q         <= {ihs_pkg::NUM_COEF{ihs_pkg::COEF_RESET}};
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ihs_pkg::CFG_BUCKETS:     bucket_count_q <= cfg_i.data;
        ihs_pkg::CFG_COEF_FIRST:  coef_q[0] <= ihs_pkg::COEF_W'(cfg_i.data);
        ihs_pkg::CFG_COEF_SECOND: coef_q[1] <= ihs_pkg::COEF_W'(cfg_i.data);
        ihs_pkg::CFG_COEF_THIRD:  coef_q[2] <= ihs_pkg::COEF_W'(cfg_i.data);
        ihs_pkg::CFG_COEF_FOURTH: coef_q[3] <= ihs_pkg::COEF_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // bucket count clamped to [2, MAX_BUCKETS]
  always_comb begin
    if (bucket_count_q < ihs_pkg::BCNT_W'(2)) begin
      n_buckets = NW'(2);
    end else if (32'(bucket_count_q) > 32'(MAX_BUCKETS)) begin
      n_buckets = NW'(MAX_BUCKETS);
    end else begin
      n_buckets = NW'(bucket_count_q);
    end
  end

  ihs_hash #(
    .BW (BW),
    .NW (NW)
  ) u_hash (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (init_done),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_cmd_i     (in_i.cmd),
    .in_addr_i    (in_i.ip_address),
    .n_i          (n_buckets),
    .coef_i       (coef_q),
    .job_valid_o  (fq_valid),
    .job_ready_i  (fq_ready),
    .job_cmd_o    (f_cmd),
    .job_addr_o   (f_addr),
    .job_bucket_o (f_bucket)
  );

  assign q_in = {f_cmd, f_addr, f_bucket};

  ihs_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (qe_valid),
    .pop_ready_i  (qe_ready),
    .pop_data_o   (q_out)
  );

  ihs_engine #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH),
    .BW          (BW),
    .NW          (NW)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_i          (n_buckets),
    .job_valid_i  (qe_valid),
    .job_ready_o  (qe_ready),
    .job_cmd_i    (q_out[JOB_W-1 -: ihs_pkg::CMD_W]),
    .job_addr_i   (q_out[BW +: ihs_pkg::ADDR_W]),
    .job_bucket_i (q_out[BW-1:0]),
    .init_done_o  (init_done),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .result_o     (result)
  );

  assign out_o.status         = result.status;
  assign out_o.insert_total   = result.insert_total;
  assign out_o.delete_total   = result.delete_total;
  assign out_o.empty_buckets  = result.empty_buckets;
  assign out_o.single_buckets = result.single_buckets;
  assign out_o.longest_chain  = result.longest_chain;
  assign out_o.longest_slot   = result.longest_slot;

endmodule

>>> verif/ihs_checker.sv
// ----------------------------------------------------------------------------
// ihs_checker
// Watches the command, result and config channels of the IPv4 hash set,
// keeps its own copy of the table, and compares every result word in order.
// ----------------------------------------------------------------------------
module ihs_checker #(
  parameter int unsigned MAX_BUCKETS = 1024,
  parameter int unsigned CHAIN_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ihs_in_if           in_i,
  ihs_out_if          out_o,
  ihs_cfg_if          cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ihs_pkg::BCNT_W-1:0] buckets_reg;
  logic [ihs_pkg::COEF_W-1:0] coef_reg [ihs_pkg::NUM_COEF];
  logic [ihs_pkg::ADDR_W-1:0] table_addr [MAX_BUCKETS][CHAIN_DEPTH];
  int unsigned                table_len [MAX_BUCKETS];
  logic [ihs_pkg::CNT_W-1:0]  inserts_done, deletes_done;
  int unsigned                mark_len, mark_idx;
  ihs_pkg::result_t           expected_results [$];

  function automatic int unsigned active_buckets();
    int unsigned n;
    n = buckets_reg;
    if (n < 2) n = 2;
    if (n > MAX_BUCKETS) n = MAX_BUCKETS;
    return n;
  endfunction

  function automatic int unsigned hash_bucket(logic [31:0] a, int unsigned n);
    int unsigned s;
    s = a[31:24] * coef_reg[3] + a[23:16] * coef_reg[2] +
        a[15:8] * coef_reg[1] + a[7:0] * coef_reg[0];
    return s % n;
  endfunction

  function automatic int find_pos(int unsigned b, logic [31:0] a);
    for (int i = 0; i < int'(table_len[b]); i++)
      if (table_addr[b][i] == a) return i;
    return -1;
  endfunction

  function automatic ihs_pkg::result_t apply_command(ihs_pkg::cmd_e c, logic [31:0] a);
    ihs_pkg::result_t r;
    int unsigned      n, b, e, s;
    int               p;
    n = active_buckets();
    b = hash_bucket(a, n);
    r = '0;
    r.status = ihs_pkg::ST_NOT_FOUND;
    case (c)
      ihs_pkg::CMD_INSERT: begin
        if (find_pos(b, a) >= 0) r.status = ihs_pkg::ST_DUPLICATE;
        else if (table_len[b] >= CHAIN_DEPTH) r.status = ihs_pkg::ST_FULL;
        else begin
          table_addr[b][table_len[b]] = a;
          table_len[b]++;
          inserts_done++;
          r.status = ihs_pkg::ST_INSERTED;
          for (int i = 0; i < int'(n); i++)
            if (table_len[i] >= mark_len) begin
              mark_len = table_len[i];
              mark_idx = i;
            end
        end
      end
      ihs_pkg::CMD_DELETE: begin
        p = find_pos(b, a);
        if (p >= 0) begin
          for (int i = p; i + 1 < int'(table_len[b]); i++)
            table_addr[b][i] = table_addr[b][i+1];
          table_len[b]--;
          deletes_done++;
          r.status = ihs_pkg::ST_DELETED;
        end else r.status = ihs_pkg::ST_ABSENT;
      end
      ihs_pkg::CMD_LOOKUP:
        r.status = (find_pos(b, a) >= 0) ? ihs_pkg::ST_FOUND : ihs_pkg::ST_NOT_FOUND;
      default: ;
    endcase
    e = 0;
    s = 0;
    for (int i = 0; i < int'(n); i++) begin
      if (table_len[i] == 0) e++;
      else if (table_len[i] == 1) s++;
    end
    r.insert_total   = inserts_done;
    r.delete_total   = deletes_done;
    r.empty_buckets  = e[ihs_pkg::BCNT_W-1:0];
    r.single_buckets = s[ihs_pkg::BCNT_W-1:0];
    r.longest_chain  = mark_len[ihs_pkg::MARK_W-1:0];
    r.longest_slot   = mark_idx[ihs_pkg::SLOT_W-1:0];
    return r;
  endfunction

  task automatic report(string what, longint exp_v, longint act_v);
    $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, act_v);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ihs_pkg::result_t want;
    if (!rst_ni) begin
      buckets_reg = ihs_pkg::BUCKETS_RESET;
      for (int i = 0; i < ihs_pkg::NUM_COEF; i++) coef_reg[i] = ihs_pkg::COEF_RESET;
      for (int i = 0; i < MAX_BUCKETS; i++) table_len[i] = 0;
      inserts_done = '0;
      deletes_done = '0;
      mark_len = 0;
      mark_idx = 0;
      expected_results.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (ihs_pkg::cfg_idx_e'(cfg_i.index))
          ihs_pkg::CFG_BUCKETS:     buckets_reg = cfg_i.data;
          ihs_pkg::CFG_COEF_FIRST:  coef_reg[0] = cfg_i.data[ihs_pkg::COEF_W-1:0];
          ihs_pkg::CFG_COEF_SECOND: coef_reg[1] = cfg_i.data[ihs_pkg::COEF_W-1:0];
          ihs_pkg::CFG_COEF_THIRD:  coef_reg[2] = cfg_i.data[ihs_pkg::COEF_W-1:0];
          ihs_pkg::CFG_COEF_FOURTH: coef_reg[3] = cfg_i.data[ihs_pkg::COEF_W-1:0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready)
        expected_results = {expected_results,
                            apply_command(ihs_pkg::cmd_e'(in_i.cmd), in_i.ip_address)};
      if (out_o.valid && out_o.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, status %0d", $time, out_o.status);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (out_o.status != want.status) report("status", want.status, out_o.status);
          if (out_o.insert_total != want.insert_total)
            report("insert_total", want.insert_total, out_o.insert_total);
          if (out_o.delete_total != want.delete_total)
            report("delete_total", want.delete_total, out_o.delete_total);
          if (out_o.empty_buckets != want.empty_buckets)
            report("empty_buckets", want.empty_buckets, out_o.empty_buckets);
          if (out_o.single_buckets != want.single_buckets)
            report("single_buckets", want.single_buckets, out_o.single_buckets);
          if (out_o.longest_chain != want.longest_chain)
            report("longest_chain", want.longest_chain, out_o.longest_chain);
          if (out_o.longest_slot != want.longest_slot)
            report("longest_slot", want.longest_slot, out_o.longest_slot);
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

>>> verif/tb_ipv4_chained_hash_set_top.sv
// ----------------------------------------------------------------------------
// tb_ipv4_chained_hash_set_top
// Drives insert, delete, lookup and reserved words into the hash set under
// several table settings and idle patterns; a checker judges every result.
// ----------------------------------------------------------------------------
module tb_ipv4_chained_hash_set_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count, pending;
  int unsigned send_idle_pct, recv_stall_pct;
  bit          hold_off;
  logic [31:0] addr_pool [$];

  ihs_in_if  in_ch ();
  ihs_out_if out_ch ();
  ihs_cfg_if cfg_ch ();

  ipv4_chained_hash_set_top dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (in_ch), .out_o (out_ch), .cfg_i (cfg_ch)
  );

  ihs_checker checker_u (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_i (in_ch), .out_o (out_ch), .cfg_i (cfg_ch),
    .fail_count_o (fail_count), .pending_o (pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #400ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(ihs_pkg::cfg_idx_e idx, int unsigned val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[10:0];
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_word(ihs_pkg::cmd_e c, logic [31:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.ip_address <= a;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // checker updates its count at the rising edge, so look at the falling one
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (2200) @(posedge clk_i);
  endtask

  // mostly addresses from a small pool so chains fill, deletes hit and
  // duplicates occur; a few new random ones, half with a small low half
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    if (addr_pool.size() == 0 || $urandom_range(3) == 0) begin
      a = $urandom;
      if ($urandom_range(1)) a[15:0] = 16'($urandom_range(40));
      if (addr_pool.size() < 48) addr_pool = {addr_pool, a};
      return a;
    end
    return addr_pool[$urandom_range(addr_pool.size() - 1)];
  endfunction

  task automatic random_run(int unsigned count);
    ihs_pkg::cmd_e c;
    int unsigned   r;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(99);
      c = r < 50 ? ihs_pkg::CMD_INSERT : r < 75 ? ihs_pkg::CMD_DELETE :
          r < 97 ? ihs_pkg::CMD_LOOKUP : ihs_pkg::CMD_RSVD;
      send_word(c, pick_addr());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = ihs_pkg::CMD_INSERT;
    in_ch.ip_address = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ihs_pkg::CFG_BUCKETS;
    cfg_ch.data = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset coefficients, small table; fill one chain past full
    write_reg(ihs_pkg::CFG_BUCKETS, 3);
    send_word(ihs_pkg::CMD_INSERT, 32'h0000_0000);
    send_word(ihs_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_word(ihs_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_word(ihs_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
    send_word(ihs_pkg::CMD_LOOKUP, 32'h1234_5678);
    for (int i = 1; i <= 8; i++) send_word(ihs_pkg::CMD_INSERT, 32'(i * 3));
    send_word(ihs_pkg::CMD_DELETE, 32'h0000_0009);
    send_word(ihs_pkg::CMD_DELETE, 32'h0000_0009);
    send_word(ihs_pkg::CMD_INSERT, 32'h0000_0009);
    send_word(ihs_pkg::CMD_RSVD, 32'hFFFF_FFFF);
    send_word(ihs_pkg::CMD_LOOKUP, 32'h0000_0000);
    send_word(ihs_pkg::CMD_DELETE, 32'h0000_0000);
    settle();

    // a zero and a maximal coefficient, and bucket count clamps at both ends
    write_reg(ihs_pkg::CFG_BUCKETS, 0);
    write_reg(ihs_pkg::CFG_COEF_FIRST, 0);
    write_reg(ihs_pkg::CFG_COEF_FOURTH, 1023);
    send_word(ihs_pkg::CMD_INSERT, 32'h0100_00FF);
    send_word(ihs_pkg::CMD_INSERT, 32'h0100_0000);
    send_word(ihs_pkg::CMD_LOOKUP, 32'h0100_00AA);
    settle();
    write_reg(ihs_pkg::CFG_BUCKETS, 2047);
    send_word(ihs_pkg::CMD_INSERT, 32'h8000_0001);
    send_word(ihs_pkg::CMD_LOOKUP, 32'h0100_00FF);
    settle();

    // random phases over several settings and idle patterns
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(ihs_pkg::CFG_BUCKETS, 7); send_idle_pct = 0; recv_stall_pct = 0;
        end
        1: begin
          write_reg(ihs_pkg::CFG_BUCKETS, 2); send_idle_pct = 70; recv_stall_pct = 0;
        end
        2: begin
          write_reg(ihs_pkg::CFG_BUCKETS, 1024); send_idle_pct = 0; recv_stall_pct = 70;
        end
        3: begin
          write_reg(ihs_pkg::CFG_BUCKETS, 13); send_idle_pct = 26; recv_stall_pct = 26;
        end
        default: begin
          write_reg(ihs_pkg::CFG_BUCKETS, 5); send_idle_pct = 0; recv_stall_pct = 0;
        end
      endcase
      write_reg(ihs_pkg::CFG_COEF_FIRST, $urandom_range(1023));
      write_reg(ihs_pkg::CFG_COEF_SECOND, $urandom_range(1023));
      write_reg(ihs_pkg::CFG_COEF_THIRD, $urandom_range(1023));
      write_reg(ihs_pkg::CFG_COEF_FOURTH, ph == 4 ? 1 : $urandom_range(1023));
      addr_pool.delete();
      if (ph == 0) begin
        // long receiver hold-off while words keep coming, fills the queue
        hold_off = 1'b1;
        fork
          begin repeat (4000) @(posedge clk_i); hold_off = 1'b0; end
        join_none
      end
      random_run(ph == 2 ? 60 : 115);
      settle();
    end

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
